[design/apst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apst_pkg
// shared types, refrigerant constant tables and fixed-point constants
// ----------------------------------------------------------------------------
package apst_pkg;

    localparam int NUM_REFRIGERANTS = 23;
    localparam int SEL_W   = 5;
    localparam int PRES_W  = 18;
    localparam int K_W     = 5;
    localparam int U_W     = 31;
    localparam int ACC_W   = 20;
    localparam int LOG_CELLS = 20;
    localparam int DEN_W   = 28;
    localparam int Q_W     = 18;
    localparam int REM_W   = DEN_W + Q_W;
    localparam int T_W     = 22;
    localparam int TEMP_W  = 16;
    localparam int ST_W    = 3;

    localparam int LN2_Q20    = 726817;
    localparam int LN1000_Q20 = 7243306;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_NONPOS  = 3'd1,
        ST_NEAR    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_CLAMP   = 3'd4
    } t_status;

    typedef int t_int_tab [NUM_REFRIGERANTS];
    typedef logic [ACC_W-1:0] t_step_tab [LOG_CELLS];
    typedef logic [24:0] t_a1q_tab [NUM_REFRIGERANTS];
    typedef logic [REM_W-1:0] t_n0_tab [NUM_REFRIGERANTS];

    localparam t_int_tab A1_MILLI = '{
        9936, 9715, 9770, 9400, 9993, 9975, 9922, 10060, 10072, 10091, 10086,
        10271, 10043, 10027, 10661, 10760, 9748, 9322, 9664, 9644, 9775, 10068,
        9430};
    localparam t_int_tab A2_TENTHS = '{
        -21479, -19464, -19746, -19907, -20214, -20197, -20235, -20374, -20597,
        -20350, -19900, -20596, -19960, -20580, -19045, -23073, -20172, -22039,
        -20558, -21083, -21797, -21114, -19421};
    localparam t_int_tab A3_TENTHS = '{
        2423, 2458, 2488, 2539, 2422, 2424, 2471, 2411, 2411, 2413, 2487, 2521,
        2481, 2473, 2679, 2479, 2478, 2482, 2423, 2482, 2420, 2489, 2535};
    localparam t_int_tab GLIDE_TENTHS = '{
        0, 5, 0, 0, 54, 50, 37, 53, 59, 53, 1, 0, 12, 54, 0, 0, 0, 0, 0, 0, 0,
        113, 0};

    // ln(1 + 2^-i) in q20 for i = 1..20
    localparam t_step_tab LN_STEP = '{
        20'd425161, 20'd233983, 20'd123504, 20'd63570, 20'd32266, 20'd16257,
        20'd8160, 20'd4088, 20'd2046, 20'd1024, 20'd512, 20'd256, 20'd128,
        20'd64, 20'd32, 20'd16, 20'd8, 20'd4, 20'd2, 20'd1};

    function automatic t_a1q_tab calc_a1q();
        t_a1q_tab tab;
        longint v;
        for (int i = 0; i < NUM_REFRIGERANTS; i++) begin
            v = (longint'(A1_MILLI[i]) * 64'sd1048576 + 64'sd500) / 64'sd1000;
            tab[i] = v[24:0];
        end
        return tab;
    endfunction

    function automatic t_n0_tab calc_n0();
        t_n0_tab tab;
        longint v;
        for (int i = 0; i < NUM_REFRIGERANTS; i++) begin
            v = longint'(A2_TENTHS[i]) * 64'sd10485760;
            if (v < 0) begin
                v = -v;
            end
            tab[i] = v[REM_W-1:0];
        end
        return tab;
    endfunction

    localparam t_a1q_tab A1Q_TAB = calc_a1q();
    localparam t_n0_tab  N0_TAB  = calc_n0();

    typedef struct packed {
        logic             valid;
        logic             dew;
        logic             zero;
        logic [K_W-1:0]   k;
        logic [U_W-1:0]   u;
        logic [ACC_W-1:0] acc;
    } t_log_beat;

    typedef struct packed {
        logic             valid;
        logic             dew;
        t_status          status;
        logic             neg;
        logic             ovf;
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } t_div_beat;

endpackage
`default_nettype wire

[design/antoine_pressure_to_saturation_temp_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// antoine_pressure_to_saturation_temp_core
// pressure in millibar to refrigerant saturation temperature in 0.01 degC
// ----------------------------------------------------------------------------
// Accepts one pressure beat per cycle while the output is not stalled and returns
// one result beat per input, in order, through 43 register stages: one input
// stage, a row of 20 log cells, three denominator stages, a row of 18 divider
// cells and the output register.
// The whole pipe advances together, so a stalled output holds every stage.
// The refrigerant register must only be written while the pipe is empty.
module antoine_pressure_to_saturation_temp_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [17:0] i_pressure_mbar,
    input  wire logic        i_want_dew_point,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [15:0] o_temperature_centi,
    output logic [2:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data
);

    localparam int LC = apst_pkg::LOG_CELLS;
    localparam int QW = apst_pkg::Q_W;

    logic en;
    logic [apst_pkg::SEL_W-1:0] r_sel;
    logic unknown;
    logic [apst_pkg::SEL_W-1:0] idx;

    assign en          = !o_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign unknown     = (32'(r_sel) >= 32'(apst_pkg::NUM_REFRIGERANTS));
    assign idx         = unknown ? '0 : r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sel <= i_cfg_data;
        end
    end

    // input stage: normalize pressure to mantissa in [1,2)
    apst_pkg::t_log_beat n_in;
    apst_pkg::t_log_beat r_in;
    logic [apst_pkg::K_W-1:0] k_enc;

    always_comb begin
        k_enc = '0;
        for (int b = 1; b < apst_pkg::PRES_W; b++) begin
            if (i_pressure_mbar[b]) begin
                k_enc = apst_pkg::K_W'(b);
            end
        end
        n_in.valid = i_in_valid && en;
        n_in.dew   = i_want_dew_point;
        n_in.zero  = (i_pressure_mbar == '0);
        n_in.k     = k_enc;
        n_in.u     = apst_pkg::U_W'(i_pressure_mbar) << (5'd30 - k_enc);
        n_in.acc   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (en) begin
            r_in.valid <= n_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in.dew  <= n_in.dew;
            r_in.zero <= n_in.zero;
            r_in.k    <= n_in.k;
            r_in.u    <= n_in.u;
            r_in.acc  <= n_in.acc;
        end
    end

    // log cell row
    apst_pkg::t_log_beat log_chain [LC+1];
    assign log_chain[0] = r_in;

    for (genvar g = 0; g < LC; g++) begin : g_log
        apst_log_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (5'(g + 1)),
            .i_step  (apst_pkg::LN_STEP[g]),
            .i_beat  (log_chain[g]),
            .o_beat  (log_chain[g+1])
        );
    end

    // denominator d = ln(p) - ln(1000) - a1
    apst_pkg::t_log_beat lg;
    logic [31:0] frac;
    logic signed [apst_pkg::DEN_W-1:0] ln_v;
    logic signed [apst_pkg::DEN_W-1:0] n_d;
    logic signed [apst_pkg::DEN_W-1:0] r_d;
    logic r1_valid, r1_dew, r1_neg_a2;
    apst_pkg::t_status n1_status, r1_status;

    assign lg = log_chain[LC];

    always_comb begin
        frac = (32'h8000_0000 - {1'b0, lg.u}) >> 11;
        ln_v = apst_pkg::DEN_W'((32'(lg.k) + 32'd1) * 32'(apst_pkg::LN2_Q20))
             - apst_pkg::DEN_W'(lg.acc) - apst_pkg::DEN_W'(frac);
        n_d  = ln_v - apst_pkg::DEN_W'(apst_pkg::LN1000_Q20)
             - apst_pkg::DEN_W'(apst_pkg::A1Q_TAB[idx]);
        if (unknown) begin
            n1_status = apst_pkg::ST_UNKNOWN;
        end else if (lg.zero) begin
            n1_status = apst_pkg::ST_NONPOS;
        end else begin
            n1_status = apst_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= lg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d       <= n_d;
            r1_dew    <= lg.dew;
            r1_status <= n1_status;
            r1_neg_a2 <= (apst_pkg::A2_TENTHS[idx] < 0);
        end
    end

    // magnitudes and rounded dividend
    apst_pkg::t_div_beat n2, r2;
    logic [apst_pkg::DEN_W-1:0] ad;

    always_comb begin
        ad        = r_d[apst_pkg::DEN_W-1] ? apst_pkg::DEN_W'(-r_d) : apst_pkg::DEN_W'(r_d);
        n2.valid  = r1_valid;
        n2.dew    = r1_dew;
        n2.status = r1_status;
        if (r1_status == apst_pkg::ST_OK && r_d >= -2'sd1 && r_d <= 2'sd1) begin
            n2.status = apst_pkg::ST_NEAR;
        end
        n2.neg = r1_neg_a2 ^ r_d[apst_pkg::DEN_W-1];
        n2.ovf = 1'b0;
        n2.den = ad;
        n2.rem = apst_pkg::N0_TAB[idx] + apst_pkg::REM_W'(ad >> 1);
        n2.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2.valid <= 1'b0;
        end else if (en) begin
            r2.valid <= n2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2.dew    <= n2.dew;
            r2.status <= n2.status;
            r2.neg    <= n2.neg;
            r2.ovf    <= n2.ovf;
            r2.den    <= n2.den;
            r2.rem    <= n2.rem;
            r2.q      <= n2.q;
        end
    end

    // quotient range check
    apst_pkg::t_div_beat n3, r3;

    always_comb begin
        n3     = r2;
        n3.ovf = (r2.rem >= {r2.den, QW'(0)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3.valid <= 1'b0;
        end else if (en) begin
            r3.valid <= n3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3.dew    <= n3.dew;
            r3.status <= n3.status;
            r3.neg    <= n3.neg;
            r3.ovf    <= n3.ovf;
            r3.den    <= n3.den;
            r3.rem    <= n3.rem;
            r3.q      <= n3.q;
        end
    end

    // divider cell row, msb first
    apst_pkg::t_div_beat div_chain [QW+1];
    assign div_chain[0] = r3;

    for (genvar g = 0; g < QW; g++) begin : g_div
        apst_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (5'(QW - 1 - g)),
            .i_beat  (div_chain[g]),
            .o_beat  (div_chain[g+1])
        );
    end

    // offset, dew shift and clamp
    apst_pkg::t_div_beat dv;
    logic signed [apst_pkg::T_W-1:0] qs, t_v;
    logic signed [apst_pkg::TEMP_W-1:0] n_temp, r_temp;
    apst_pkg::t_status n_status, r_status;

    assign dv = div_chain[QW];

    always_comb begin
        qs  = dv.neg ? -apst_pkg::T_W'(dv.q) : apst_pkg::T_W'(dv.q);
        t_v = qs - apst_pkg::T_W'(apst_pkg::A3_TENTHS[idx] * 10);
        if (dv.dew) begin
            t_v = t_v + apst_pkg::T_W'(apst_pkg::GLIDE_TENTHS[idx] * 5);
        end
        n_status = dv.status;
        n_temp   = '0;
        if (dv.status == apst_pkg::ST_OK) begin
            if (dv.ovf) begin
                n_status = apst_pkg::ST_CLAMP;
                n_temp   = dv.neg ? 16'sh8000 : 16'sh7fff;
            end else if (t_v > 22'sd32767) begin
                n_status = apst_pkg::ST_CLAMP;
                n_temp   = 16'sh7fff;
            end else if (t_v < -22'sd32768) begin
                n_status = apst_pkg::ST_CLAMP;
                n_temp   = 16'sh8000;
            end else begin
                n_temp   = t_v[apst_pkg::TEMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= dv.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp   <= n_temp;
            r_status <= n_status;
        end
    end

    assign o_temperature_centi = r_temp;
    assign o_status            = r_status;

    a_err_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == apst_pkg::ST_NONPOS || o_status == apst_pkg::ST_NEAR
            || o_status == apst_pkg::ST_UNKNOWN) |-> o_temperature_centi == 16'sd0)
        else $error("error status with nonzero temperature");

    a_clamp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == apst_pkg::ST_CLAMP
            |-> (o_temperature_centi == 16'sh7fff || o_temperature_centi == 16'sh8000))
        else $error("clamp status without limit value");

    a_unknown_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !unknown |-> o_status != apst_pkg::ST_UNKNOWN)
        else $error("unknown status with valid refrigerant");

endmodule
`default_nettype wire

[design/apst_log_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apst_log_cell
// one step of the shift-and-add log: multiply by (1 + 2^-i) when it stays below 2
// ----------------------------------------------------------------------------
module apst_log_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic [4:0]               i_shift,
    input  wire logic [apst_pkg::ACC_W-1:0] i_step,
    input  wire apst_pkg::t_log_beat      i_beat,
    output apst_pkg::t_log_beat           o_beat
);

    apst_pkg::t_log_beat r_beat;
    apst_pkg::t_log_beat n_beat;
    logic [apst_pkg::U_W:0] t_sum;

    always_comb begin
        t_sum  = {1'b0, i_beat.u} + ({1'b0, i_beat.u} >> i_shift);
        n_beat = i_beat;
        if (!t_sum[apst_pkg::U_W]) begin
            n_beat.u   = t_sum[apst_pkg::U_W-1:0];
            n_beat.acc = i_beat.acc + i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= n_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat.dew  <= n_beat.dew;
            r_beat.zero <= n_beat.zero;
            r_beat.k    <= n_beat.k;
            r_beat.u    <= n_beat.u;
            r_beat.acc  <= n_beat.acc;
        end
    end

    assign o_beat = r_beat;

endmodule
`default_nettype wire

[design/apst_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apst_div_cell
// one restoring division step producing one quotient bit
// ----------------------------------------------------------------------------
module apst_div_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic [4:0]          i_shift,
    input  wire apst_pkg::t_div_beat i_beat,
    output apst_pkg::t_div_beat      o_beat
);

    apst_pkg::t_div_beat r_beat;
    apst_pkg::t_div_beat n_beat;
    logic [apst_pkg::REM_W-1:0] cmp;

    always_comb begin
        cmp    = apst_pkg::REM_W'(i_beat.den) << i_shift;
        n_beat = i_beat;
        if (i_beat.rem >= cmp) begin
            n_beat.rem = i_beat.rem - cmp;
            n_beat.q   = i_beat.q | (apst_pkg::Q_W'(1) << i_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= n_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat.dew    <= n_beat.dew;
            r_beat.status <= n_beat.status;
            r_beat.neg    <= n_beat.neg;
            r_beat.ovf    <= n_beat.ovf;
            r_beat.den    <= n_beat.den;
            r_beat.rem    <= n_beat.rem;
            r_beat.q      <= n_beat.q;
        end
    end

    assign o_beat = r_beat;

endmodule
`default_nettype wire
